FILE: design/dfl_pkg.sv
// Shared types and constants for the delimited field locator.
// Used by dfl_track, dfl_result and delimited_field_locate; no dependencies.
package dfl_pkg;

  // Line and field geometry
  localparam int          MaxLineBytes  = 65536;
  localparam int          MaxDelimBytes = 4;
  localparam int          OfsW          = 17;
  localparam int          LenW          = 16;
  localparam int          CntW          = 16;
  localparam int          DlenW         = 3;
  localparam int          DelimW        = 8 * MaxDelimBytes;

  localparam logic [OfsW-1:0] MaxLine   = OfsW'(MaxLineBytes);
  localparam logic [OfsW-1:0] OfsAbsent = '1;
  localparam logic [LenW-1:0] LenMax    = '1;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  // Configuration register indexes
  localparam logic [1:0] CfgDelimBytes = 2'd0;
  localparam logic [1:0] CfgDelimLen   = 2'd1;
  localparam logic [1:0] CfgFieldNum   = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_FEW   = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  // Per-line tracking state, also handed over as a snapshot at end of line
  typedef struct packed {
    logic            too_long;
    logic [CntW-1:0] delims_seen;
    logic [OfsW-1:0] target_start;
    logic            target_closed;
    logic [OfsW-1:0] close_pos;
    logic            start_is_break;
    logic            content_seen;
    logic [OfsW-1:0] last_content;
  } line_st_t;

endpackage

FILE: design/delimited_field_locate.sv
// Delimited field locator: one line byte per item, one result per line.
// Throughput one byte per cycle while the output is not held, set by the tracking update.
// The final byte passes the input register, snapshot register and output register
// in that order before the result is valid; a held output can stall it between them.
// Reset (rst_ni low, asynchronous) restores TAB delimiter, length 1, field 0
// and clears all line state; no clearing pass is needed.
module delimited_field_locate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  line_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [16:0] start_offset_o,
  output logic signed [16:0] end_offset_o,
  output logic [15:0] field_length_o
);
  import dfl_pkg::*;

  logic [DelimW-1:0] delim_bytes_q;
  logic [DlenW-1:0]  delim_len_q;
  logic [CntW-1:0]   field_number_q;

  logic              snap_valid;
  logic              snap_take;
  line_st_t          snap;
  status_e           status;
  logic [OfsW-1:0]   start_ofs;
  logic [OfsW-1:0]   end_ofs;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q  <= DelimW'(9);
      delim_len_q    <= DlenW'(1);
      field_number_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDelimBytes: delim_bytes_q  <= cfg_data_i;
        CfgDelimLen:   delim_len_q    <= cfg_data_i[DlenW-1:0];
        CfgFieldNum:   field_number_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  dfl_track u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .line_byte_i    (line_byte_i),
    .last_byte_i    (last_byte_i),
    .delim_bytes_i  (delim_bytes_q),
    .delim_len_i    (delim_len_q),
    .field_number_i (field_number_q),
    .snap_take_i    (snap_take),
    .snap_valid_o   (snap_valid),
    .snap_o         (snap)
  );

  dfl_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid),
    .snap_i         (snap),
    .snap_take_o    (snap_take),
    .field_number_i (field_number_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status),
    .start_offset_o (start_ofs),
    .end_offset_o   (end_ofs),
    .field_length_o (field_length_o)
  );

  assign status_o       = status;
  assign start_offset_o = start_ofs;
  assign end_offset_o   = end_ofs;

`ifndef ASSERT_OFF
  // A missing or overlong field reports absent offsets and zero length
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |->
      start_offset_o == OfsAbsent && end_offset_o == OfsAbsent &&
      field_length_o == '0)
    else $error("absent field without -1 offsets");

  // A found field never ends before it starts
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FOUND |->
      end_ofs >= start_ofs && start_ofs != OfsAbsent)
    else $error("field end before start");

  // A waiting snapshot is not dropped while the output is held
  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid && !snap_take |=> snap_valid)
    else $error("line snapshot lost");
`endif

endmodule

FILE: design/dfl_track.sv
// Input register and per-line delimiter tracking for the field locator.
// Hands a snapshot of the line state to the result stage on the final byte.
// Depends on dfl_pkg.
module dfl_track (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                line_byte_i,
  input  logic                      last_byte_i,
  input  logic [dfl_pkg::DelimW-1:0] delim_bytes_i,
  input  logic [dfl_pkg::DlenW-1:0]  delim_len_i,
  input  logic [dfl_pkg::CntW-1:0]   field_number_i,
  input  logic                      snap_take_i,
  output logic                      snap_valid_o,
  output dfl_pkg::line_st_t         snap_o
);
  import dfl_pkg::*;

  logic                    in_valid_q;
  logic [7:0]              byte_q;
  logic                    last_q;
  logic                    adv;

  line_st_t                st_q, st_d;
  logic [OfsW-1:0]         pos_q, pos_d;
  logic [OfsW-1:0]         nma_q, nma_d;
  logic [23:0]             recent_q, recent_d;

  logic                    snap_valid_q;
  line_st_t                snap_q;

  logic [DlenW-1:0]        dl;
  logic [DelimW-1:0]       window;
  logic [MaxDelimBytes:1]  pat_eq;
  logic                    pat_hit;
  logic                    room;
  logic                    hit;
  logic                    brk;
  logic                    is_target;
  logic [CntW-1:0]         ds_inc;

  // Input register: non-final bytes always move on, a final byte waits for
  // the snapshot slot
  assign adv        = in_valid_q && (!last_q || !snap_valid_q || snap_take_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= line_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Effective delimiter length: zero reads as one, clamp at the maximum
  always_comb begin
    if (delim_len_i == '0) begin
      dl = DlenW'(1);
    end else if (delim_len_i > DlenW'(MaxDelimBytes)) begin
      dl = DlenW'(MaxDelimBytes);
    end else begin
      dl = delim_len_i;
    end
  end

  // Delimiter compare: newest bytes against the whole delimiter, newest byte against its last character
  assign window = {recent_q, byte_q};

  always_comb begin
    for (int l = 1; l <= MaxDelimBytes; l++) begin
      pat_eq[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (window[8*j +: 8] != delim_bytes_i[8*(l-1-j) +: 8]) begin
          pat_eq[l] = 1'b0;
        end
      end
    end
    pat_hit = pat_eq[dl];
  end

  // No overlap with the previous match, and enough bytes seen
  assign room = ({1'b0, pos_q} + (OfsW+1)'(1)) >= ({1'b0, nma_q} + (OfsW+1)'(dl));
  assign hit  = room && pat_hit;
  assign brk  = (byte_q == ChLf) || (byte_q == ChCr);
  assign is_target = (st_q.delims_seen == field_number_i) && !st_q.target_closed;
  assign ds_inc = (st_q.delims_seen != '1) ? st_q.delims_seen + CntW'(1)
                                           : st_q.delims_seen;

  // Line state update for the byte in the input register
  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    nma_d    = nma_q;
    recent_d = recent_q;
    if (st_q.too_long || pos_q >= MaxLine) begin
      st_d.too_long = 1'b1;
    end else begin
      recent_d = {recent_q[15:0], byte_q};
      if (is_target && pos_q == st_q.target_start) begin
        st_d.start_is_break = brk;
      end
      if (!brk) begin
        st_d.last_content = pos_q;
        st_d.content_seen = 1'b1;
      end
      if (hit) begin
        if (is_target) begin
          st_d.target_closed = 1'b1;
          st_d.close_pos     = pos_q + OfsW'(1) - OfsW'(dl);
        end
        st_d.delims_seen = ds_inc;
        if (ds_inc == field_number_i) begin
          st_d.target_start = pos_q + OfsW'(1);
        end
        nma_d = pos_q + OfsW'(1);
      end
      pos_d = pos_q + OfsW'(1);
    end
  end

  // State registers, cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      pos_q    <= '0;
      nma_q    <= '0;
      recent_q <= '0;
    end else if (adv) begin
      if (last_q) begin
        st_q     <= '0;
        pos_q    <= '0;
        nma_q    <= '0;
        recent_q <= '0;
      end else begin
        st_q     <= st_d;
        pos_q    <= pos_d;
        nma_q    <= nma_d;
        recent_q <= recent_d;
      end
    end
  end

  // Snapshot slot towards the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      snap_valid_q <= 1'b1;
    end else if (snap_take_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      snap_q <= st_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

FILE: design/dfl_result.sv
// Result stage of the field locator: turns a line snapshot into status,
// offsets and length, held in an output register. Depends on dfl_pkg.
module dfl_result (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      snap_valid_i,
  input  dfl_pkg::line_st_t         snap_i,
  output logic                      snap_take_o,
  input  logic [dfl_pkg::CntW-1:0]   field_number_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dfl_pkg::status_e          status_o,
  output logic [dfl_pkg::OfsW-1:0]   start_offset_o,
  output logic [dfl_pkg::OfsW-1:0]   end_offset_o,
  output logic [dfl_pkg::LenW-1:0]   field_length_o
);
  import dfl_pkg::*;

  logic            out_valid_q;
  logic            out_free;
  status_e         status_q, status_d;
  logic [OfsW-1:0] start_q, start_d;
  logic [OfsW-1:0] end_q, end_d;
  logic [LenW-1:0] len_q, len_d;
  logic [OfsW-1:0] s;
  logic [OfsW-1:0] len_full;

  assign out_free    = !out_valid_q || out_ready_i;
  assign snap_take_o = out_free;
  assign s           = snap_i.target_start;

  // Field bounds from the snapshot
  always_comb begin
    len_full = '0;
    end_d    = s;
    if (snap_i.target_closed) begin
      if (snap_i.close_pos > s) begin
        end_d    = snap_i.close_pos - OfsW'(1);
        len_full = snap_i.close_pos - s;
        // lone CR or LF before a delimiter counts as empty
        if (len_full == OfsW'(1) && snap_i.start_is_break) begin
          len_full = '0;
        end
      end
    end else if (snap_i.content_seen && snap_i.last_content >= s) begin
      end_d    = snap_i.last_content;
      len_full = snap_i.last_content - s + OfsW'(1);
    end
  end

  // Status selection and length saturation
  always_comb begin
    if (snap_i.too_long) begin
      status_d = ST_LONG;
      start_d  = OfsAbsent;
    end else if (snap_i.delims_seen < field_number_i) begin
      status_d = ST_FEW;
      start_d  = OfsAbsent;
    end else begin
      status_d = ST_FOUND;
      start_d  = s;
    end
    len_d = (len_full > OfsW'(LenMax)) ? LenMax : len_full[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_valid_i) begin
      status_q <= status_d;
      start_q  <= start_d;
      if (status_d == ST_FOUND) begin
        end_q <= end_d;
        len_q <= len_d;
      end else begin
        end_q <= OfsAbsent;
        len_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign start_offset_o = start_q;
  assign end_offset_o   = end_q;
  assign field_length_o = len_q;

endmodule

FILE: test/dfl_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the delimited field locator: follows the register writes and
// the byte stream, predicts each line's field location and checks the results.
// Depends on dfl_pkg for widths, character codes, register indexes and status.
module dfl_checker
  import dfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  line_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [16:0] start_offset_i,
  input  logic [16:0] end_offset_i,
  input  logic [15:0] field_length_i,
  input  logic        drained_i,
  output int          results_o,
  output int          fail_count_o
);

  // One predicted line result
  typedef struct packed {
    status_e         status;
    logic [OfsW-1:0] start_ofs;
    logic [OfsW-1:0] end_ofs;
    logic [LenW-1:0] len;
  } field_loc_t;

  field_loc_t pending_locs[$];

  // Register copies
  logic [31:0]      dl_bytes;
  logic [DlenW-1:0] dl_len;
  logic [CntW-1:0]  fld_num;

  // Line tracking copy
  int unsigned pos, delims, next_ok, tgt_start, close_pos, last_content;
  logic [31:0] recent;
  bit          tgt_closed, content_seen, too_long, start_brk;

  int  n_results, n_fail;
  bit  leftover_done;

  task automatic clear_line_state();
    pos          = 0;
    delims       = 0;
    recent       = '0;
    next_ok      = 0;
    tgt_start    = 0;
    tgt_closed   = 1'b0;
    close_pos    = 0;
    last_content = 0;
    content_seen = 1'b0;
    too_long     = 1'b0;
    start_brk    = 1'b0;
  endtask

  // Advance the line state by one byte; on the final byte queue the result
  task automatic locate_byte(input logic [7:0] b, input logic is_last);
    int unsigned p, dl, s, e, len, k;
    bit          brk, hit;
    field_loc_t  loc;
    p = pos;
    if (too_long || p >= MaxLineBytes) begin
      too_long = 1'b1;
    end else begin
      dl = dl_len;
      if (dl == 0) dl = 1;
      if (dl > MaxDelimBytes) dl = MaxDelimBytes;
      brk = (b == ChLf) || (b == ChCr);
      recent = {recent[23:0], b};
      if (delims == fld_num && !tgt_closed && p == tgt_start) start_brk = brk;
      if (!brk) begin
        last_content = p;
        content_seen = 1'b1;
      end
      // leftmost, non-overlapping: no match may reuse bytes of the previous one
      hit = (p + 1 >= next_ok + dl);
      for (k = 0; k < dl; k++) begin
        if (recent[8*(dl-1-k) +: 8] != dl_bytes[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        if (delims == fld_num && !tgt_closed) begin
          tgt_closed = 1'b1;
          close_pos  = p + 1 - dl;
        end
        if (delims < LenMax) delims++;
        if (delims == fld_num) tgt_start = p + 1;
        next_ok = p + 1;
      end
      pos = p + 1;
    end

    if (is_last) begin
      if (too_long || delims < fld_num) begin
        loc.status    = too_long ? ST_LONG : ST_FEW;
        loc.start_ofs = OfsAbsent;
        loc.end_ofs   = OfsAbsent;
        loc.len       = '0;
      end else begin
        s = tgt_start;
        if (tgt_closed) begin
          if (close_pos <= s) begin
            e   = s;
            len = 0;
          end else begin
            e = close_pos - 1;
            // a lone CR or LF before a delimiter counts as empty
            if (e == s) len = start_brk ? 0 : 1;
            else len = e - s + 1;
          end
        end else if (content_seen && last_content >= s) begin
          e   = last_content;
          len = e - s + 1;
        end else begin
          e   = s;
          len = 0;
        end
        if (len > LenMax) len = LenMax;
        loc.status    = ST_FOUND;
        loc.start_ofs = s[OfsW-1:0];
        loc.end_ofs   = e[OfsW-1:0];
        loc.len       = len[LenW-1:0];
      end
      pending_locs.push_back(loc);
      clear_line_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    field_loc_t want;
    if (!rst_ni) begin
      dl_bytes = 32'h0000_0009;  // TAB
      dl_len   = 3'd1;
      fld_num  = '0;
      clear_line_state();
      pending_locs.delete();
      n_results     = 0;
      n_fail        = 0;
      leftover_done = 1'b0;
    end else begin
      // results first: a line accepted now cannot have its result yet
      if (out_valid_i && out_ready_i) begin
        n_results++;
        if (pending_locs.size() == 0) begin
          $error("field result arrived with nothing expected");
          n_fail++;
        end else begin
          want = pending_locs.pop_front();
          if (status_i != want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            n_fail++;
          end
          if (start_offset_i != want.start_ofs) begin
            $error("start_offset: expected %0d, got %0d",
                   $signed(want.start_ofs), $signed(start_offset_i));
            n_fail++;
          end
          if (end_offset_i != want.end_ofs) begin
            $error("end_offset: expected %0d, got %0d",
                   $signed(want.end_ofs), $signed(end_offset_i));
            n_fail++;
          end
          if (field_length_i != want.len) begin
            $error("field_length: expected %0d, got %0d", want.len, field_length_i);
            n_fail++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDelimBytes: dl_bytes = cfg_data_i;
          CfgDelimLen:   dl_len   = cfg_data_i[DlenW-1:0];
          CfgFieldNum:   fld_num  = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) locate_byte(line_byte_i, last_byte_i);

      if (drained_i && !leftover_done) begin
        leftover_done = 1'b1;
        if (pending_locs.size() != 0) begin
          $error("%0d expected field results never arrived", pending_locs.size());
          n_fail++;
        end
      end
    end
    results_o    <= n_results;
    fail_count_o <= n_fail;
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the delimited field locator testbench: directed and random lines under
// several delimiter and field settings, with random idling on both channels.
// Depends on dfl_pkg, delimited_field_locate and the dfl_checker scoreboard.
module tb_top;
  import dfl_pkg::*;

  localparam int CycleLimit     = 1_000_000;
  localparam int PressureCycles = 300;
  localparam int PhaseItems     = 150;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgDelimBytes;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  line_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic signed [16:0] start_offset_o;
  logic signed [16:0] end_offset_o;
  logic [15:0] field_length_o;

  logic drained = 1'b0;
  int   results_seen, fail_count;
  int   lines_sent = 0;
  int   cycle_cnt  = 0;
  bit   quiet      = 1'b0;  // no idling on either side
  logic hold_req   = 1'b0;
  bit   hold_done  = 1'b0;

  logic [7:0] line_buf[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  delimited_field_locate uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .line_byte_i    (line_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .field_length_o (field_length_o)
  );

  dfl_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .line_byte_i    (line_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .start_offset_i (start_offset_o),
    .end_offset_i   (end_offset_o),
    .field_length_i (field_length_o),
    .drained_i      (drained),
    .results_o      (results_seen),
    .fail_count_o   (fail_count)
  );

  // Offer one byte; valid is left high so a back-to-back item keeps it up
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_byte_i <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
    line_buf = {};
  endtask

  task automatic load_text(input string s);
    int i;
    line_buf = {};
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_seen < lines_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] dbytes, input logic [31:0] dlen,
                            input logic [31:0] fnum);
    wait_idle();
    cfg_write(CfgDelimBytes, dbytes);
    cfg_write(CfgDelimLen, dlen);
    cfg_write(CfgFieldNum, fnum);
    cfg_valid_i <= 1'b0;
  endtask

  // Random line byte, biased towards delimiter characters and line breaks
  function automatic logic [7:0] pick_byte(input logic [31:0] dbytes);
    int r, k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, 3);
    if (r < 3) return dbytes[8*k +: 8];
    if (r < 7) return 8'(8'h61 + $urandom_range(0, 3));
    if (r == 7) return $urandom_range(0, 1) ? ChCr : ChLf;
    return 8'($urandom);
  endfunction

  // Well-formed line of fields joined by the delimiter, or occasional noise
  task automatic build_line(input logic [31:0] dbytes, input int eff);
    int nf, f, flen, k, n;
    line_buf = {};
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) line_buf.push_back(8'($urandom));
    end else begin
      nf = $urandom_range(1, 6);
      for (f = 0; f < nf; f++) begin
        flen = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        repeat (flen) line_buf.push_back(pick_byte(dbytes));
        if (f < nf - 1) begin
          for (k = 0; k < eff; k++) line_buf.push_back(dbytes[8*k +: 8]);
        end
      end
      case ($urandom_range(0, 5))
        0: begin
          line_buf.push_back(ChCr);
          line_buf.push_back(ChLf);
        end
        1: line_buf.push_back(ChLf);
        2: line_buf.push_back(ChCr);
        default: ;
      endcase
    end
    if (line_buf.size() == 0) line_buf.push_back(8'h7A);
  endtask

  // Cycle limit
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random ready gaps, one long hold-off on request
  initial begin : receiver
    int gap, held;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        held = 0;
        while (held < PressureCycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_done = 1'b1;
      end
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int ph, sent, eff, k, n;
    logic [31:0] dbytes, dlen, fnum;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset setting: TAB, one byte, field 0
    load_text("a\tb");
    send_line();
    load_text("\t");                   // empty first field
    send_line();
    load_text("\015\tx");              // lone CR before a delimiter
    send_line();
    load_text("xy\015\012");           // trailing CR/LF dropped
    send_line();
    load_text("\012");                 // last field holds only a break
    send_line();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    send_line();

    // Two-byte delimiter: matches must not overlap
    set_config(32'h0000_3A3A, 32'd2, 32'd1);
    load_text(":::x");
    send_line();
    load_text("ab");                   // too few fields
    send_line();

    // All-ones delimiter, length above the maximum, highest field number
    set_config(32'hFFFF_FFFF, 32'd7, 32'h0000_FFFF);
    repeat (5) line_buf.push_back(8'hFF);
    send_line();

    // Zero delimiter with length zero, read as one; each zero byte is a delimiter
    set_config(32'h0000_0000, 32'd0, 32'd2);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h41);
    line_buf.push_back(8'h00);
    send_line();

    // Random phases, each with its own setting
    for (ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        dbytes = $urandom;
      end else begin
        for (k = 0; k < 4; k++) begin
          case ($urandom_range(0, 5))
            0: dbytes[8*k +: 8] = 8'h2C;
            1: dbytes[8*k +: 8] = 8'h3A;
            2: dbytes[8*k +: 8] = 8'h09;
            3: dbytes[8*k +: 8] = 8'h61;
            4: dbytes[8*k +: 8] = ChCr;
            default: dbytes[8*k +: 8] = 8'($urandom);
          endcase
        end
      end
      case ($urandom_range(0, 9))
        0: dlen = 32'd0;
        1: dlen = $urandom_range(5, 7);
        default: dlen = $urandom_range(1, 4);
      endcase
      eff = (dlen == 0) ? 1 : ((dlen > 4) ? 4 : dlen);
      if ($urandom_range(0, 1) == 1) dlen = ($urandom & ~32'h7) | dlen;
      case ($urandom_range(0, 9))
        0: fnum = $urandom_range(0, 65535);
        1: fnum = 32'h0000_FFFF;
        default: fnum = $urandom_range(0, 5);
      endcase
      if ($urandom_range(0, 1) == 1) fnum = {16'($urandom), fnum[15:0]};
      set_config(dbytes, dlen, fnum);

      // first phase: receiver holds off while short lines keep coming
      if (ph == 0) begin
        quiet = 1'b1;
        hold_req <= 1'b1;
        repeat (40) begin
          n = $urandom_range(1, 3);
          repeat (n) line_buf.push_back(pick_byte(dbytes));
          send_line();
        end
      end
      quiet = (ph == 3);

      sent = 0;
      while (sent < PhaseItems) begin
        build_line(dbytes, eff);
        sent += line_buf.size();
        send_line();
      end
      quiet = 1'b0;
    end

    wait_idle();
    drained <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
